// ----- sv/bmoc_pkg.sv -----
// Shared types, constants and helpers for the two-stage binary morphology block.
// Used by bmoc_stage and binary_morph_open_close; depends on nothing.
`default_nettype none

package bmoc_pkg;

  localparam int WIN = 5;
  localparam int ELEMS = WIN * WIN;
  localparam int OW = 3;

  localparam logic [2:0] REG_IMG_COLS      = 3'd0;
  localparam logic [2:0] REG_IMG_ROWS      = 3'd1;
  localparam logic [2:0] REG_MODE          = 3'd2;
  localparam logic [2:0] REG_FIRST_MASK    = 3'd3;
  localparam logic [2:0] REG_FIRST_ORIGIN  = 3'd4;
  localparam logic [2:0] REG_SECOND_MASK   = 3'd5;
  localparam logic [2:0] REG_SECOND_ORIGIN = 3'd6;

  typedef struct packed {
    logic emit2;
    logic last;
  } tag_t;

  // clamp origin code and split it into {row, col}
  function automatic logic [2*OW-1:0] origin_rc(input logic [4:0] o);
    logic [4:0] oc;
    logic [OW-1:0] row;
    logic [4:0] base;
    oc = (o > 5'(ELEMS - 1)) ? 5'(ELEMS - 1) : o;
    if (oc >= 5'd20) row = 3'd4;
    else if (oc >= 5'd15) row = 3'd3;
    else if (oc >= 5'd10) row = 3'd2;
    else if (oc >= 5'd5) row = 3'd1;
    else row = 3'd0;
    base = 5'(row) * 5'(WIN);
    return {row, 3'(oc - base)};
  endfunction

endpackage

`default_nettype wire

// ----- sv/bmoc_stage.sv -----
// One morphology stage: column line store, 5x5 window and erosion/dilation logic.
// Depends on bmoc_pkg.
`default_nettype none

module bmoc_stage #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             en,
  input  wire logic [$clog2(MAX_COLS+1)-1:0]    cols,
  input  wire logic [$clog2(MAX_ROWS+1)-1:0]    rows,
  input  wire logic                             erode,
  input  wire logic [bmoc_pkg::ELEMS-1:0]       mask,
  input  wire logic [bmoc_pkg::OW-1:0]          orow,
  input  wire logic [bmoc_pkg::OW-1:0]          ocol,
  input  wire logic                             in_valid,
  input  wire logic                             in_pix,
  input  wire logic                             in_emit,
  input  wire bmoc_pkg::tag_t                   in_tag,
  output logic                                  out_valid,
  output logic                                  out_pix,
  output bmoc_pkg::tag_t                        out_tag
);

  localparam int W   = bmoc_pkg::WIN;
  localparam int AW  = $clog2(MAX_COLS);
  localparam int CW  = $clog2(MAX_COLS + 1);
  localparam int RW  = $clog2(MAX_ROWS + 8);

  logic [W-2:0] mem [MAX_COLS];
  logic [W-2:0] rd;
  logic [AW-1:0] ci;

  logic valid1, pix1, emit1;
  logic [AW-1:0] c1;
  bmoc_pkg::tag_t tag1;

  logic valid2, emit2;
  bmoc_pkg::tag_t tag2;
  logic [W-1:0] win [W];
  logic [RW-1:0] rm;
  logic [AW-1:0] cm;

  logic [W-1:0] newcol;
  logic [bmoc_pkg::ELEMS-1:0] fail, take;
  logic hit;

  assign newcol = {rd, pix1};

  always_ff @(posedge clk) begin
    if (en && valid1) begin
      mem[c1] <= newcol[W-2:0];
    end
    if (en && in_valid) begin
      rd <= (valid1 && c1 == ci) ? newcol[W-2:0] : mem[ci];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ci <= '0;
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      rm <= '0;
      cm <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      valid1 <= in_valid;
      if (in_valid) begin
        if (in_tag.last || CW'(ci) == cols - CW'(1)) ci <= '0;
        else ci <= ci + AW'(1);
      end
      valid2 <= valid1;
      if (valid2 && emit2) begin
        if (tag2.last) begin
          rm <= '0;
          cm <= '0;
        end else if (CW'(cm) == cols - CW'(1)) begin
          cm <= '0;
          rm <= rm + RW'(1);
        end else begin
          cm <= cm + AW'(1);
        end
      end
      out_valid <= valid2 && emit2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix1 <= in_pix;
      c1 <= ci;
      emit1 <= in_emit;
      tag1 <= in_tag;
      emit2 <= emit1;
      tag2 <= tag1;
      if (valid1) begin
        win[0] <= newcol;
        for (int b = 1; b < W; b++) win[b] <= win[b-1];
      end
      out_pix <= hit && (rm < RW'(rows));
      out_tag <= tag2;
    end
  end

  always_comb begin
    int di, dj, tr, tc, a, b;
    logic ok, member, px;
    for (int i = 0; i < W; i++) begin
      for (int j = 0; j < W; j++) begin
        if (erode) begin
          a = W - 1 - i;
          b = W - 1 - j;
          di = i - int'(orow);
          dj = j - int'(ocol);
        end else begin
          a = i;
          b = j;
          di = int'(orow) - i;
          dj = int'(ocol) - j;
        end
        tr = int'(rm) + di;
        tc = int'(cm) + dj;
        ok = (tr >= 0) && (tr < int'(rows)) && (tc >= 0) && (tc < int'(cols));
        px = ok && win[b][a];
        member = mask[i*W+j] || (erode && i == int'(orow) && j == int'(ocol));
        fail[i*W+j] = member && !px;
        take[i*W+j] = member && px;
      end
    end
    hit = erode ? ~|fail : |take;
  end

endmodule

`default_nettype wire

// ----- sv/binary_morph_open_close.sv -----
// Top level of the two-stage binary morphology block (opening / closing).
// Depends on bmoc_pkg and bmoc_stage.
//
// Usage: pixels arrive in raster order on the s_ channel, one transaction
// per pixel; s_tuser high marks a flush transaction that carries no pixel.
// After the last image pixel, send flush transactions until the result
// marked with m_tlast appears; the block is then ready for the next frame.
// Flush transactions before the image end are taken and dropped.
// Results leave on the m_ channel, one per pixel, in raster order.
// Throughput: one transaction per cycle while m_tready is high and no
// hold-off runs. The result for pixel k follows input transaction k+L1+L2
// through the input register and both stages; L1 and L2 are the window
// delays of the stages (up to 4 lines + 4 pixels, set by origins and width).
// Configuration: cfg_index/cfg_data written through cfg_valid/cfg_ready,
// only while idle (a rule for the user; the block does not enforce it).
// Reset: registers take their defaults (1024x1024, opening, 3x3 squares),
// the frame position returns to zero. Input is held off after reset and
// after each write until the settle counter runs out. Stall: a result held
// with m_tready low freezes the whole pipeline and drops s_tready.
`default_nettype none

module binary_morph_open_close #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,    // [0] pixel_in
  input  wire logic        s_tuser,    // [0] is_flush
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,    // [0] result_pixel
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [24:0] cfg_data
);

  localparam int CW  = $clog2(MAX_COLS + 1);
  localparam int RHW = $clog2(MAX_ROWS + 1);
  localparam int TW  = $clog2(MAX_COLS * (MAX_ROWS + 8) + 8);
  localparam int OW  = bmoc_pkg::OW;
  localparam logic [OW-1:0] WM1 = OW'(bmoc_pkg::WIN - 1);

  logic [10:0] img_cols, img_rows;
  logic mode;
  logic [24:0] first_mask, second_mask;
  logic [4:0] first_origin, second_origin;

  logic [CW-1:0] cols;
  logic [RHW-1:0] rows;
  logic [OW-1:0] orow1, ocol1, orow2, ocol2;
  logic erode1;
  logic [TW-1:0] lat1, lat2, total, latsum, tend;
  logic [1:0] settle;

  logic en, accept, drop, in_img;
  logic [TW-1:0] t;

  logic in_valid, in_pix, in_emit;
  bmoc_pkg::tag_t in_tag;

  logic s1_valid, s1_pix;
  bmoc_pkg::tag_t s1_tag;
  logic s2_pix;
  bmoc_pkg::tag_t s2_tag;

  assign cfg_ready = 1'b1;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en && (settle == 2'd0);
  assign accept = s_tvalid && s_tready;
  assign in_img = t < total;
  assign drop = s_tuser && in_img;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_cols <= 11'd1024;
      img_rows <= 11'd1024;
      mode <= 1'b0;
      first_mask <= 25'd473536;
      first_origin <= 5'd12;
      second_mask <= 25'd473536;
      second_origin <= 5'd12;
      settle <= 2'd3;
    end else begin
      if (cfg_valid && cfg_ready) begin
        settle <= 2'd3;
        case (cfg_index)
          bmoc_pkg::REG_IMG_COLS:      img_cols <= cfg_data[10:0];
          bmoc_pkg::REG_IMG_ROWS:      img_rows <= cfg_data[10:0];
          bmoc_pkg::REG_MODE:          mode <= cfg_data[0];
          bmoc_pkg::REG_FIRST_MASK:    first_mask <= cfg_data;
          bmoc_pkg::REG_FIRST_ORIGIN:  first_origin <= cfg_data[4:0];
          bmoc_pkg::REG_SECOND_MASK:   second_mask <= cfg_data;
          bmoc_pkg::REG_SECOND_ORIGIN: second_origin <= cfg_data[4:0];
          default: ;
        endcase
      end else if (settle != 2'd0) begin
        settle <= settle - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (img_cols == 11'd0) cols <= CW'(1);
    else if (32'(img_cols) > MAX_COLS) cols <= CW'(MAX_COLS);
    else cols <= CW'(img_cols);
    if (img_rows == 11'd0) rows <= RHW'(1);
    else if (32'(img_rows) > MAX_ROWS) rows <= RHW'(MAX_ROWS);
    else rows <= RHW'(img_rows);
    {orow1, ocol1} <= bmoc_pkg::origin_rc(first_origin);
    {orow2, ocol2} <= bmoc_pkg::origin_rc(second_origin);
    erode1 <= !mode;
    total <= TW'(cols) * TW'(rows);
    lat1 <= erode1 ? TW'(WM1 - orow1) * TW'(cols) + TW'(WM1 - ocol1)
                   : TW'(orow1) * TW'(cols) + TW'(ocol1);
    lat2 <= erode1 ? TW'(orow2) * TW'(cols) + TW'(ocol2)
                   : TW'(WM1 - orow2) * TW'(cols) + TW'(WM1 - ocol2);
    latsum <= lat1 + lat2;
    tend <= total - TW'(1) + lat1 + lat2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t <= '0;
      in_valid <= 1'b0;
    end else if (en) begin
      in_valid <= accept && !drop;
      if (accept && !drop) begin
        t <= (t == tend) ? '0 : t + TW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_pix <= s_tdata[0] && !s_tuser && in_img;
      in_emit <= t >= lat1;
      in_tag.emit2 <= t >= latsum;
      in_tag.last <= t == tend;
    end
  end

  bmoc_stage #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_first (
    .clk(clk), .rst(rst), .en(en), .cols(cols), .rows(rows),
    .erode(erode1), .mask(first_mask), .orow(orow1), .ocol(ocol1),
    .in_valid(in_valid), .in_pix(in_pix), .in_emit(in_emit), .in_tag(in_tag),
    .out_valid(s1_valid), .out_pix(s1_pix), .out_tag(s1_tag)
  );

  bmoc_stage #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_second (
    .clk(clk), .rst(rst), .en(en), .cols(cols), .rows(rows),
    .erode(!erode1), .mask(second_mask), .orow(orow2), .ocol(ocol2),
    .in_valid(s1_valid), .in_pix(s1_pix), .in_emit(s1_tag.emit2), .in_tag(s1_tag),
    .out_valid(m_tvalid), .out_pix(s2_pix), .out_tag(s2_tag)
  );

  assign m_tdata = {7'd0, s2_pix};
  assign m_tlast = s2_tag.last;

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for binary_morph_open_close (two-stage opening / closing).
// Directed frames from a table, then random frames under changing stall patterns.
// Depends on bmoc_pkg and the RTL of the block; results are checked in raster order.
`timescale 1ns / 1ps

module tb_top;

  localparam int MAXC = 1024;
  localparam int MAXR = 1024;
  localparam int HIST = (bmoc_pkg::WIN - 1) * MAXC + bmoc_pkg::WIN;
  localparam int N_ITEMS = 800;

  typedef struct packed {
    logic pix;
    logic last;
  } px_t;

  typedef struct {
    int unsigned cols;
    int unsigned rows;
    bit          mode;
    logic [24:0] m1;
    logic [4:0]  o1;
    logic [24:0] m2;
    logic [4:0]  o2;
    logic [24:0] pat;
    bit          noise;
    bit          typed;
    logic [24:0] expv;
  } frame_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [24:0] cfg_data = '0;

  binary_morph_open_close i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  px_t         pending_pixels[$];
  int          errors = 0;
  int          n_results = 0;
  int          n_frames = 0;
  int          n_pixels = 0;
  int          n_items = 0;
  int          send_idle = 0;
  int          recv_idle = 0;

  // shadow registers and line history
  int unsigned sh_cols, sh_rows, sh_mode, sh_org1, sh_org2;
  logic [24:0] sh_mask1, sh_mask2;
  bit          hist1[HIST];
  bit          hist2[HIST];
  int unsigned in_pos;

  // current frame bookkeeping
  int unsigned frame_total, frame_k;
  bit          frame_done, typed_on;
  logic [24:0] typed_px;

  function automatic int unsigned fit_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic int unsigned fit_org(int unsigned o);
    return (o > bmoc_pkg::ELEMS - 1) ? bmoc_pkg::ELEMS - 1 : o;
  endfunction

  function automatic int unsigned window_delay(bit erode, int unsigned org, int unsigned cols);
    if (erode) begin
      return (bmoc_pkg::WIN - 1 - org / bmoc_pkg::WIN) * cols
             + (bmoc_pkg::WIN - 1 - org % bmoc_pkg::WIN);
    end
    return (org / bmoc_pkg::WIN) * cols + org % bmoc_pkg::WIN;
  endfunction

  function automatic bit fetch(bit sec, int r, int c, int unsigned cols, int unsigned rows);
    int unsigned s;
    if (r < 0 || c < 0 || r >= int'(rows) || c >= int'(cols)) return 1'b0;
    s = r * cols + c;
    return sec ? hist2[s % HIST] : hist1[s % HIST];
  endfunction

  function automatic bit morph(bit sec, int unsigned m, bit erode, logic [24:0] mask,
                               int unsigned org, int unsigned cols, int unsigned rows);
    int r, c, orow, ocol;
    if (m >= cols * rows) return 1'b0;
    r = m / cols;
    c = m % cols;
    orow = org / bmoc_pkg::WIN;
    ocol = org % bmoc_pkg::WIN;
    if (erode && !fetch(sec, r, c, cols, rows)) return 1'b0;
    for (int i = 0; i < bmoc_pkg::WIN; i++) begin
      for (int j = 0; j < bmoc_pkg::WIN; j++) begin
        if (!mask[i * bmoc_pkg::WIN + j]) continue;
        if (erode) begin
          if (!fetch(sec, r + i - orow, c + j - ocol, cols, rows)) return 1'b0;
        end else begin
          if (fetch(sec, r - i + orow, c - j + ocol, cols, rows)) return 1'b1;
        end
      end
    end
    return erode;
  endfunction

  function automatic bit advance_pixel(bit pix, bit flush, output px_t res);
    int unsigned cols, rows, total, t, org1, org2, lat1, lat2, m, o;
    bit erode1;
    cols = fit_dim(sh_cols, MAXC);
    rows = fit_dim(sh_rows, MAXR);
    total = cols * rows;
    t = in_pos;
    erode1 = (sh_mode == 0);
    org1 = fit_org(sh_org1);
    org2 = fit_org(sh_org2);
    lat1 = window_delay(erode1, org1, cols);
    lat2 = window_delay(!erode1, org2, cols);
    res = '0;
    if (flush && t < total) return 1'b0;
    hist1[t % HIST] = (!flush && t < total) ? pix : 1'b0;
    in_pos = t + 1;
    if (t < lat1) return 1'b0;
    m = t - lat1;
    hist2[m % HIST] = morph(1'b0, m, erode1, sh_mask1, org1, cols, rows);
    if (m < lat2) return 1'b0;
    o = m - lat2;
    if (o >= total) begin
      in_pos = 0;
      return 1'b0;
    end
    res.pix = morph(1'b1, o, !erode1, sh_mask2, org2, cols, rows);
    res.last = (o == total - 1);
    if (res.last) in_pos = 0;
    return 1'b1;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [24:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bmoc_pkg::REG_IMG_COLS:      sh_cols  = val[10:0];
      bmoc_pkg::REG_IMG_ROWS:      sh_rows  = val[10:0];
      bmoc_pkg::REG_MODE:          sh_mode  = val[0];
      bmoc_pkg::REG_FIRST_MASK:    sh_mask1 = val;
      bmoc_pkg::REG_FIRST_ORIGIN:  sh_org1  = val[4:0];
      bmoc_pkg::REG_SECOND_MASK:   sh_mask2 = val;
      bmoc_pkg::REG_SECOND_ORIGIN: sh_org2  = val[4:0];
      default: ;
    endcase
  endtask

  task automatic configure(int unsigned cols, int unsigned rows, bit md, logic [24:0] m1,
                           logic [4:0] o1, logic [24:0] m2, logic [4:0] o2);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    write_reg(bmoc_pkg::REG_IMG_COLS, 25'(cols));
    write_reg(bmoc_pkg::REG_IMG_ROWS, 25'(rows));
    write_reg(bmoc_pkg::REG_MODE, 25'(md));
    write_reg(bmoc_pkg::REG_FIRST_MASK, m1);
    write_reg(bmoc_pkg::REG_FIRST_ORIGIN, 25'(o1));
    write_reg(bmoc_pkg::REG_SECOND_MASK, m2);
    write_reg(bmoc_pkg::REG_SECOND_ORIGIN, 25'(o2));
    cfg_valid <= 1'b0;
  endtask

  task automatic take(bit pix, bit flush);
    px_t r;
    bit got;
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, pix};
    s_tuser  <= flush;
    do @(posedge clk); while (!s_tready);
    n_items++;
    got = advance_pixel(pix, flush, r);
    if (got) begin
      if (typed_on) begin
        r.pix = typed_px[frame_k];
        r.last = (frame_k == frame_total - 1);
      end
      pending_pixels.push_back(r);
      frame_k++;
      if (r.last) frame_done = 1'b1;
    end
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic run_frame(bit use_pat, logic [24:0] pat, bit noise, bit typed,
                           logic [24:0] expv);
    frame_total = fit_dim(sh_cols, MAXC) * fit_dim(sh_rows, MAXR);
    frame_k = 0;
    frame_done = 1'b0;
    typed_on = typed;
    typed_px = expv;
    for (int unsigned i = 0; i < frame_total; i++) begin
      if (noise && $urandom_range(9) == 0) take(1'($urandom_range(1)), 1'b1);
      take(use_pat ? pat[i] : 1'($urandom_range(1)), 1'b0);
    end
    while (!frame_done) take(1'($urandom_range(1)), $urandom_range(3) != 0);
    s_tvalid <= 1'b0;
    n_frames++;
  endtask

  function automatic logic [24:0] pick_mask();
    case ($urandom_range(3))
      0: return 25'($urandom);
      1: return 25'($urandom & $urandom & $urandom);
      2: return 25'($urandom | $urandom | $urandom);
      default: return $urandom_range(1) ? '0 : '1;
    endcase
  endfunction

  always @(posedge clk) begin
    m_tready <= !rst && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    px_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected result transaction: result_pixel=%0b last_pixel=%0b",
               m_tdata[0], m_tlast);
        errors++;
      end else begin
        e = pending_pixels.pop_front();
        n_results++;
        if (m_tdata[0] !== e.pix) begin
          $error("result_pixel: expected %0b, actual %0b", e.pix, m_tdata[0]);
          errors++;
        end
        if (m_tlast !== e.last) begin
          $error("last_pixel: expected %0b, actual %0b", e.last, m_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    frame_row_t rows_tbl[7];
    int rand_base;
    rows_tbl = '{
      '{1, 1, 1'b0, 25'h739C0, 5'd12, 25'h739C0, 5'd12, 25'h1, 1'b0, 1'b0, 25'h0},
      '{0, 0, 1'b1, 25'h1FFFFFF, 5'd0, 25'h1FFFFFF, 5'd31, 25'h1, 1'b0, 1'b0, 25'h0},
      '{3, 2, 1'b0, 25'h0, 5'd12, 25'h1000, 5'd12, 25'h2D, 1'b0, 1'b1, 25'h2D},
      '{3, 2, 1'b1, 25'h1000, 5'd12, 25'h0, 5'd12, 25'h12, 1'b0, 1'b1, 25'h12},
      '{2, 2, 1'b0, 25'h1FFFFFF, 5'd7, 25'h0, 5'd3, 25'hF, 1'b0, 1'b1, 25'h0},
      '{4, 4, 1'b1, 25'h1FFFFFF, 5'd24, 25'h1FFFFFF, 5'd0, 25'hA5F0, 1'b1, 1'b0, 25'h0},
      '{5, 5, 1'b0, 25'h1FFFFFF, 5'd31, 25'h1FFFFFF, 5'd0, 25'h1FFFFFF, 1'b0, 1'b0, 25'h0}
    };
    sh_cols = 1024; sh_rows = 1024; sh_mode = 0;
    sh_mask1 = 25'h739C0; sh_mask2 = 25'h739C0; sh_org1 = 12; sh_org2 = 12;
    in_pos = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (rows_tbl[i]) begin
      configure(rows_tbl[i].cols, rows_tbl[i].rows, rows_tbl[i].mode, rows_tbl[i].m1,
                rows_tbl[i].o1, rows_tbl[i].m2, rows_tbl[i].o2);
      run_frame(1'b1, rows_tbl[i].pat, rows_tbl[i].noise, rows_tbl[i].typed,
                rows_tbl[i].expv);
    end

    rand_base = n_items;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 17 : (ph == 1) ? 87 : 0;
      recv_idle = (ph == 0) ? 87 : (ph == 1) ? 17 : 0;
      while (n_items < rand_base + (N_ITEMS - rand_base) * (ph + 1) / 3) begin
        configure($urandom_range(12), $urandom_range(8), 1'($urandom_range(1)),
                  pick_mask(), 5'($urandom_range(31)), pick_mask(),
                  5'($urandom_range(31)));
        n_pixels += fit_dim(sh_cols, MAXC) * fit_dim(sh_rows, MAXR);
        run_frame(1'b0, '0, 1'($urandom_range(1)), 1'b0, '0);
      end
    end

    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d frames (directed and random, opening and closing), %0d results.",
             n_frames, n_results);
    $display("Sent %0d input transactions; random frames held %0d pixels under three stall patterns.",
             n_items, n_pixels);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- files.f -----
sv/bmoc_pkg.sv
sv/bmoc_stage.sv
sv/binary_morph_open_close.sv
dv/tb_top.sv
